// ===== src/lz4bc_pkg.sv =====
// Package for the LZ4 block compressor.
// Holds default sizes, hash and length-coding constants and the one-hot code types.
// No dependencies.
`default_nettype none

package lz4bc_pkg;

    // Default block store size in bytes and hash table index width.
    localparam int BLOCK_BYTES_DEF = 4096;
    localparam int HASH_BITS_DEF   = 12;

    // Multiplicative hash constant (golden ratio).
    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

    // Length coding constants.
    localparam int MIN_MATCH      = 4;
    localparam int NIBBLE_MAX     = 15;
    localparam int EXT_BYTE_MAX   = 255;

    // Width of the reported compressed length.
    localparam int LEN_W = 13;

    // Sequencer states.
    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_WORD    = 10'b00_0000_0010,
        ST_HASH    = 10'b00_0000_0100,
        ST_HT_RD   = 10'b00_0000_1000,
        ST_HT_WR   = 10'b00_0001_0000,
        ST_CMP     = 10'b00_0010_0000,
        ST_EXT_RD  = 10'b00_0100_0000,
        ST_EXT_CMP = 10'b00_1000_0000,
        ST_EMIT    = 10'b01_0000_0000,
        ST_SPARE   = 10'b10_0000_0000
    } seq_state_t;

    // Output phases of the compressed stream.
    typedef enum logic [6:0] {
        PH_LOAD   = 7'b000_0001,
        PH_TOKEN  = 7'b000_0010,
        PH_LITEXT = 7'b000_0100,
        PH_LIT    = 7'b000_1000,
        PH_OFFLO  = 7'b001_0000,
        PH_OFFHI  = 7'b010_0000,
        PH_MEXT   = 7'b100_0000
    } phase_t;

endpackage

`default_nettype wire

// ===== src/lz4_block_compressor.sv =====
// LZ4 block compressor: block store, hash table and the match/emit sequencer; uses lz4bc_pkg.
// Load beats are taken one per cycle while no output byte is pending. A fetch with no block ready
// yields a registered byte with out_valid low, and the next beat is taken once a byte has left. A
// token fetch searches first: word read, hash, table read and write, candidate compare, then match
// extension byte by byte. Reset and each block end start a pass that clears all 2^HASH_BITS table
// entries, with no beat accepted. Control registers reset asynchronously; payload ones do not.
`default_nettype none

module lz4_block_compressor #(
    parameter int BLOCK_BYTES = lz4bc_pkg::BLOCK_BYTES_DEF,
    parameter int HASH_BITS   = lz4bc_pkg::HASH_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] kind
    input  wire logic        s_tlast,   // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] out_byte, [20:8] out_length, [23:21] zero
    output logic             m_tuser,   // [0] out_valid
    output logic             m_tlast    // out_last
);
    import lz4bc_pkg::*;

    localparam int POS_W  = $clog2(BLOCK_BYTES);
    localparam int CNT_W  = $clog2(BLOCK_BYTES + 1);
    localparam int HSIZE  = 1 << HASH_BITS;

    // Memories.
    logic [7:0]       src_mem [BLOCK_BYTES];
    logic [POS_W-1:0] ht_mem  [HSIZE];

    logic             src_we;
    logic [POS_W-1:0] src_wa, src_ra, src_rb;
    logic [7:0]       src_wd, src_qa_reg, src_qb_reg;
    logic             ht_we;
    logic [HASH_BITS-1:0] ht_wa, ht_ra;
    logic [POS_W-1:0] ht_wd, ht_q_reg;

    // Control and datapath registers.
    seq_state_t       state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] load_count_reg, load_count_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] anchor_reg, anchor_next;
    logic [POS_W-1:0] ref_reg, ref_next;
    logic [POS_W-1:0] cand_reg, cand_next;
    logic [CNT_W-1:0] extra_reg, extra_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] out_count_reg, out_count_next;
    logic [31:0]      word_reg, word_next;
    logic [31:0]      cword_reg, cword_next;
    logic [31:0]      prod_reg, prod_next;
    logic [2:0]       idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic             clr_busy_reg, clr_busy_next;
    logic [HASH_BITS-1:0] clr_idx_reg, clr_idx_next;
    logic             mv_reg, mv_next;
    logic             oval_reg, oval_next;
    logic [7:0]       obyte_reg, obyte_next;
    logic             olast_reg, olast_next;
    logic [LEN_W-1:0] olen_reg, olen_next;

    // Helper values.
    logic             accept;
    logic [CNT_W:0]   scan_p4;
    logic [CNT_W:0]   scan_p5;
    logic [CNT_W:0]   ext_p;
    logic [CNT_W-1:0] lit_len;
    logic [CNT_W-1:0] fm_scan;
    logic [16:0]      offset;
    logic [31:0]      cword_full;
    phase_t           after_lit;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE) && !mv_reg && !clr_busy_reg;
    assign scan_p4    = {1'b0, scan_reg} + (CNT_W+1)'(MIN_MATCH);
    assign scan_p5    = {1'b0, scan_reg} + (CNT_W+1)'(MIN_MATCH + 1);
    assign ext_p      = scan_p4 + {1'b0, extra_reg};
    assign lit_len    = scan_reg - anchor_reg;
    assign fm_scan    = scan_reg + CNT_W'(MIN_MATCH) + extra_reg;
    assign offset     = 17'(scan_reg) - 17'(ref_reg);
    assign cword_full = {src_qb_reg, cword_reg[31:8]};
    assign after_lit  = (ref_reg != '0) ? PH_OFFLO : PH_LOAD;

    assign m_tvalid = mv_reg;
    assign m_tuser  = oval_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {3'b000, olen_reg, obyte_reg};

    // Source store: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (src_we)
        begin
            src_mem[src_wa] <= src_wd;
        end
        src_qa_reg <= src_mem[src_ra];
        src_qb_reg <= src_mem[src_rb];
    end

    // Hash table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ht_we)
        begin
            ht_mem[ht_wa] <= ht_wd;
        end
        ht_q_reg <= ht_mem[ht_ra];
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        load_count_next = load_count_reg;
        scan_next       = scan_reg;
        anchor_next     = anchor_reg;
        ref_next        = ref_reg;
        cand_next       = cand_reg;
        extra_next      = extra_reg;
        rem_next        = rem_reg;
        out_count_next  = out_count_reg;
        word_next       = word_reg;
        cword_next      = cword_reg;
        prod_next       = prod_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        clr_busy_next   = clr_busy_reg;
        clr_idx_next    = clr_idx_reg;
        mv_next         = mv_reg && !m_tready;
        oval_next       = oval_reg;
        obyte_next      = obyte_reg;
        olast_next      = olast_reg;
        olen_next       = olen_reg;

        src_we = 1'b0;
        src_wa = load_count_reg[POS_W-1:0];
        src_wd = s_tdata;
        src_ra = anchor_reg[POS_W-1:0];
        src_rb = cand_reg;
        ht_we  = 1'b0;
        ht_wa  = prod_reg[31 -: HASH_BITS];
        ht_wd  = scan_reg[POS_W-1:0];
        ht_ra  = prod_reg[31 -: HASH_BITS];

        // Hash table clearing pass.
        if (clr_busy_reg)
        begin
            ht_we        = 1'b1;
            ht_wa        = clr_idx_reg;
            ht_wd        = '0;
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == {HASH_BITS{1'b1}})
            begin
                clr_busy_next = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!s_tuser)
                    begin
                        // Load beat.
                        if (phase_reg == PH_LOAD && load_count_reg < CNT_W'(BLOCK_BYTES))
                        begin
                            src_we          = 1'b1;
                            load_count_next = load_count_reg + 1'b1;
                            if (s_tlast || load_count_next >= CNT_W'(BLOCK_BYTES))
                            begin
                                scan_next      = '0;
                                anchor_next    = '0;
                                ref_next       = '0;
                                extra_next     = '0;
                                rem_next       = '0;
                                out_count_next = '0;
                                phase_next     = PH_TOKEN;
                            end
                        end
                    end
                    else if (phase_reg == PH_LOAD)
                    begin
                        // Fetch with no block ready.
                        mv_next    = 1'b1;
                        oval_next  = 1'b0;
                        obyte_next = '0;
                        olast_next = 1'b0;
                        olen_next  = '0;
                    end
                    else if (phase_reg == PH_TOKEN)
                    begin
                        // Start the match search.
                        ref_next   = '0;
                        extra_next = '0;
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        if (scan_p4 < {1'b0, load_count_reg})
                        begin
                            state_next = ST_WORD;
                        end
                        else
                        begin
                            scan_next  = load_count_reg;
                            state_next = ST_EMIT;
                        end
                    end
                    else
                    begin
                        // Literal read is issued here for the literal phase.
                        src_ra     = anchor_reg[POS_W-1:0];
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_WORD:
            begin
                // Shift source bytes into the little-endian word window.
                if (pend_reg)
                begin
                    word_next = {src_qa_reg, word_reg[31:8]};
                end
                if (idx_reg < 3'(MIN_MATCH))
                begin
                    src_ra    = scan_reg[POS_W-1:0] + POS_W'(idx_reg);
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_HASH;
                end
            end

            ST_HASH:
            begin
                prod_next  = word_reg * HASH_MULT;
                state_next = ST_HT_RD;
            end

            ST_HT_RD:
            begin
                state_next = ST_HT_WR;
            end

            ST_HT_WR:
            begin
                // Record this position and check the candidate.
                ht_we     = 1'b1;
                cand_next = ht_q_reg;
                if (ht_q_reg != '0 && CNT_W'(ht_q_reg) < scan_reg)
                begin
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    state_next = ST_CMP;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                    pend_next = 1'b0;
                    if (scan_p5 < {1'b0, load_count_reg})
                    begin
                        idx_next   = 3'(MIN_MATCH - 1);
                        state_next = ST_WORD;
                    end
                    else
                    begin
                        scan_next  = load_count_reg;
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_CMP:
            begin
                // Read the candidate word and compare it with the window.
                if (pend_reg)
                begin
                    cword_next = cword_full;
                end
                if (idx_reg < 3'(MIN_MATCH))
                begin
                    src_rb    = cand_reg + POS_W'(idx_reg);
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (cword_full == word_reg)
                    begin
                        extra_next = '0;
                        state_next = ST_EXT_RD;
                    end
                    else
                    begin
                        scan_next = scan_reg + 1'b1;
                        if (scan_p5 < {1'b0, load_count_reg})
                        begin
                            idx_next   = 3'(MIN_MATCH - 1);
                            state_next = ST_WORD;
                        end
                        else
                        begin
                            scan_next  = load_count_reg;
                            state_next = ST_EMIT;
                        end
                    end
                end
            end

            ST_EXT_RD:
            begin
                // Extend the match one byte at a time.
                if (ext_p < {1'b0, load_count_reg})
                begin
                    src_ra     = ext_p[POS_W-1:0];
                    src_rb     = cand_reg + POS_W'(MIN_MATCH) + extra_reg[POS_W-1:0];
                    state_next = ST_EXT_CMP;
                end
                else
                begin
                    ref_next   = cand_reg;
                    state_next = ST_EMIT;
                end
            end

            ST_EXT_CMP:
            begin
                if (src_qa_reg == src_qb_reg)
                begin
                    extra_next = extra_reg + 1'b1;
                    state_next = ST_EXT_RD;
                end
                else
                begin
                    ref_next   = cand_reg;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                // Produce one compressed byte for the current phase.
                phase_next = PH_LOAD;
                obyte_next = '0;
                case (phase_reg)
                    PH_TOKEN:
                    begin
                        obyte_next[7:4] = (lit_len >= CNT_W'(NIBBLE_MAX)) ?
                                          4'(NIBBLE_MAX) : lit_len[3:0];
                        if (ref_reg != '0)
                        begin
                            obyte_next[3:0] = (extra_reg >= CNT_W'(NIBBLE_MAX)) ?
                                              4'(NIBBLE_MAX) : extra_reg[3:0];
                        end
                        if (lit_len >= CNT_W'(NIBBLE_MAX))
                        begin
                            rem_next   = lit_len - CNT_W'(NIBBLE_MAX);
                            phase_next = PH_LITEXT;
                        end
                        else if (lit_len != '0)
                        begin
                            phase_next = PH_LIT;
                        end
                        else
                        begin
                            phase_next = after_lit;
                        end
                    end
                    PH_LITEXT:
                    begin
                        if (rem_reg >= CNT_W'(EXT_BYTE_MAX))
                        begin
                            obyte_next = 8'(EXT_BYTE_MAX);
                            rem_next   = rem_reg - CNT_W'(EXT_BYTE_MAX);
                            phase_next = PH_LITEXT;
                        end
                        else
                        begin
                            obyte_next = rem_reg[7:0];
                            rem_next   = '0;
                            phase_next = (scan_reg > anchor_reg) ? PH_LIT : after_lit;
                        end
                    end
                    PH_LIT:
                    begin
                        obyte_next  = src_qa_reg;
                        anchor_next = anchor_reg + 1'b1;
                        phase_next  = (anchor_next < scan_reg) ? PH_LIT : after_lit;
                    end
                    PH_OFFLO:
                    begin
                        obyte_next = offset[7:0];
                        phase_next = PH_OFFHI;
                    end
                    PH_OFFHI, PH_MEXT:
                    begin
                        if (phase_reg == PH_OFFHI)
                        begin
                            obyte_next = offset[15:8];
                        end
                        else if (rem_reg >= CNT_W'(EXT_BYTE_MAX))
                        begin
                            obyte_next = 8'(EXT_BYTE_MAX);
                        end
                        else
                        begin
                            obyte_next = rem_reg[7:0];
                        end

                        if (phase_reg == PH_OFFHI && extra_reg >= CNT_W'(NIBBLE_MAX))
                        begin
                            rem_next   = extra_reg - CNT_W'(NIBBLE_MAX);
                            phase_next = PH_MEXT;
                        end
                        else if (phase_reg == PH_MEXT && rem_reg >= CNT_W'(EXT_BYTE_MAX))
                        begin
                            rem_next   = rem_reg - CNT_W'(EXT_BYTE_MAX);
                            phase_next = PH_MEXT;
                        end
                        else
                        begin
                            // Match done: move past it.
                            rem_next    = '0;
                            scan_next   = fm_scan;
                            anchor_next = fm_scan;
                            ref_next    = '0;
                            extra_next  = '0;
                            phase_next  = (fm_scan >= load_count_reg) ? PH_LOAD : PH_TOKEN;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_LOAD;
                    end
                endcase

                mv_next        = 1'b1;
                oval_next      = 1'b1;
                out_count_next = out_count_reg + 1'b1;
                if (phase_next == PH_LOAD)
                begin
                    // End of block: report length and restart loading.
                    olast_next      = 1'b1;
                    olen_next       = out_count_next;
                    load_count_next = '0;
                    scan_next       = '0;
                    anchor_next     = '0;
                    ref_next        = '0;
                    extra_next      = '0;
                    rem_next        = '0;
                    out_count_next  = '0;
                    clr_busy_next   = 1'b1;
                    clr_idx_next    = '0;
                end
                else
                begin
                    olast_next = 1'b0;
                    olen_next  = '0;
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_LOAD;
            load_count_reg <= '0;
            scan_reg       <= '0;
            anchor_reg     <= '0;
            ref_reg        <= '0;
            extra_reg      <= '0;
            rem_reg        <= '0;
            out_count_reg  <= '0;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            clr_busy_reg   <= 1'b1;
            clr_idx_reg    <= '0;
            mv_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            load_count_reg <= load_count_next;
            scan_reg       <= scan_next;
            anchor_reg     <= anchor_next;
            ref_reg        <= ref_next;
            extra_reg      <= extra_next;
            rem_reg        <= rem_next;
            out_count_reg  <= out_count_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            clr_busy_reg   <= clr_busy_next;
            clr_idx_reg    <= clr_idx_next;
            mv_reg         <= mv_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cand_reg  <= cand_next;
        word_reg  <= word_next;
        cword_reg <= cword_next;
        prod_reg  <= prod_next;
        oval_reg  <= oval_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
        olen_reg  <= olen_next;
    end

endmodule

`default_nettype wire
